// ----- rtl/core/ocm_pkg.sv -----
// ---------------------------------------------------------------------------
// ocm_pkg
// Shared types and constants for the oscillator capacitance meter.
// ---------------------------------------------------------------------------
package ocm_pkg;

   localparam int COUNT_BITS = 24;
   localparam int TICK_BITS  = 32;
   localparam int GATE_BITS  = 32;
   localparam int GW         = (TICK_BITS > GATE_BITS) ? TICK_BITS : GATE_BITS;

   localparam int CAL_BITS   = 24;
   localparam int OFS_BITS   = 16;
   localparam int TGT_BITS   = 10;
   localparam int TOL_BITS   = 7;
   localparam int CAP_BITS   = 28;
   localparam int T10_BITS   = 14;
   localparam int FREQ_BITS  = 24;
   localparam int NEED_BITS  = 18;
   localparam int CSR_BITS   = 32;

   // shared shift-subtract divider
   localparam int DIV_N      = 42;
   localparam int DIV_D      = 33;
   localparam int DIV_CBITS  = $clog2(DIV_N + 1);

   localparam logic [FREQ_BITS-1:0] FREQ_MAX     = '1;
   localparam int                   LIMIT_TENTHS = 99990;

   typedef enum logic [2:0] {
      CSR_GATE_TICKS    = 3'd0,
      CSR_CAL_NUMERATOR = 3'd1,
      CSR_OFFSET        = 3'd2,
      CSR_TARGET_NF     = 3'd3,
      CSR_TOLERANCE     = 3'd4,
      CSR_SERIES_MODE   = 3'd5,
      CSR_TARGET_ENABLE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_NONE   = 2'd0,
      STATUS_INSIDE = 2'd1,
      STATUS_VALID  = 2'd2,
      STATUS_CLOSE  = 2'd3
   } needed_status_type;

   typedef struct packed {
      logic [GATE_BITS-1:0] gate_ticks;
      logic [CAL_BITS-1:0]  cal_numerator;
      logic [OFS_BITS-1:0]  offset_tenths_nf;
      logic [TGT_BITS-1:0]  target_nf;
      logic [TOL_BITS-1:0]  tolerance_pct;
      logic                 series_mode;
      logic                 target_enable;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  saturated;
   } meas_type;

endpackage

// ----- rtl/core/ocm_front.sv -----
// ---------------------------------------------------------------------------
// ocm_front
// Gate tick counter and edge counter with a two-entry measurement queue.
// ---------------------------------------------------------------------------
module ocm_front
   import ocm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [GATE_BITS-1:0] gate_ticks,
   input  logic                 push,
   input  logic                 edge_seen,
   output logic                 full,
   output logic                 meas_valid,
   output meas_type             meas_head,
   input  logic                 meas_pop
);

   localparam logic [GW-1:0] TICK_MAX = GW'({TICK_BITS{1'b1}});

   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  sat_ff, sat_in;
   meas_type              q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;

   logic [GW-1:0]         gate_w, gate_eff;
   logic [TICK_BITS-1:0]  tick_next;
   logic                  gate_end, accept, hit, q_push;
   logic [COUNT_BITS-1:0] count_new;
   logic                  sat_new;

   always_comb begin
      gate_w = GW'(gate_ticks);
      if (gate_w == '0) begin
         gate_eff = GW'(1);
      end else if (gate_w > TICK_MAX) begin
         gate_eff = TICK_MAX;
      end else begin
         gate_eff = gate_w;
      end
   end

   assign tick_next = tick_ff + 1'b1;
   assign gate_end  = GW'(tick_next) >= gate_eff;
   assign full      = gate_end && (fill_ff == 2'd2);
   assign accept    = push && !full;
   assign hit       = edge_seen && (count_ff == '1);
   assign count_new = (edge_seen && !hit) ? count_ff + 1'b1 : count_ff;
   assign sat_new   = sat_ff | hit;
   assign q_push    = accept && gate_end;

   assign meas_valid = fill_ff != 2'd0;
   assign meas_head  = q_ff[rd_ptr_ff];

   always_comb begin
      tick_in   = tick_ff;
      count_in  = count_ff;
      sat_in    = sat_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (gate_end) begin
            tick_in  = '0;
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            tick_in  = tick_next;
            count_in = count_new;
            sat_in   = sat_new;
         end
      end
      if (q_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (meas_pop && meas_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(q_push) - 2'(meas_pop && meas_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         count_ff  <= '0;
         sat_ff    <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         tick_ff   <= tick_in;
         count_ff  <= count_in;
         sat_ff    <= sat_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= '{count: count_new, saturated: sat_new};
      end
   end

endmodule

// ----- rtl/core/ocm_div.sv -----
// ---------------------------------------------------------------------------
// ocm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ocm_div
   import ocm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_N-1:0] dividend,
   input  logic [DIV_D-1:0] divisor,
   output logic             done,
   output logic [DIV_N-1:0] quotient
);

   logic [DIV_D:0]     rem_ff, rem_in;
   logic [DIV_N-1:0]   quo_ff, quo_in;
   logic [DIV_D-1:0]   dvs_ff, dvs_in;
   logic [DIV_CBITS-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [DIV_D:0]     trial;
   logic               bit_ok;

   assign trial  = {rem_ff[DIV_D-1:0], quo_ff[DIV_N-1]};
   assign bit_ok = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CBITS'(DIV_N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = bit_ok ? trial - {1'b0, dvs_ff} : trial;
         quo_in = {quo_ff[DIV_N-2:0], bit_ok};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CBITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/ocm_back.sv -----
// ---------------------------------------------------------------------------
// ocm_back
// Capacitance, tolerance and needed-value sequencer with result register.
// ---------------------------------------------------------------------------
module ocm_back
   import ocm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        meas_valid,
   input  meas_type                    meas_head,
   output logic                        meas_pop,
   input  logic                        pop,
   output logic                        empty,
   output logic [FREQ_BITS-1:0]        rsp_frequency_hz,
   output logic [CAP_BITS-1:0]         rsp_cap_tenths_nf,
   output logic                        rsp_measure_error,
   output logic                        rsp_in_tolerance,
   output logic signed [NEED_BITS-1:0] rsp_needed_tenths_nf,
   output logic [1:0]                  rsp_needed_status
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIV_CAP = 5'b00010,
      ST_CHECK   = 5'b00100,
      ST_DIV_SER = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]       f_ff, f_in;
   logic                        err_ff, err_in;
   logic [CAP_BITS-1:0]         cap_ff, cap_in;
   logic                        inside_ff, inside_in;
   logic signed [NEED_BITS-1:0] need_ff, need_in;
   logic                        big_ff, big_in, close_ff, close_in;

   logic                        rv_ff, rv_in;
   logic [FREQ_BITS-1:0]        o_freq_ff, o_freq_in;
   logic [CAP_BITS-1:0]         o_cap_ff, o_cap_in;
   logic                        o_err_ff, o_err_in, o_ins_ff, o_ins_in;
   logic signed [NEED_BITS-1:0] o_need_ff, o_need_in;
   needed_status_type           o_stat_ff, o_stat_in;

   logic                        div_start, div_done, ser_neg_ff, ser_neg_in;
   logic [DIV_N-1:0]            div_dividend, div_quotient;
   logic [DIV_D-1:0]            div_divisor;

   logic [T10_BITS-1:0]         t10;
   logic signed [29:0]          diff_cap, d_ser, abs_d, need_par;
   logic [35:0]                 c100;
   logic [21:0]                 hi_bound, lo_bound;
   logic signed [8:0]           lo_factor;
   logic                        meas_err, inside_w;
   logic [32:0]                 count_w;

   ocm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign t10       = {4'b0, cfg.target_nf} * T10_BITS'(10);
   assign meas_err  = (meas_head.count == '0) || meas_head.saturated;
   assign diff_cap  = $signed({2'b0, div_quotient[CAP_BITS-1:0]})
                      - $signed({14'b0, cfg.offset_tenths_nf});
   assign d_ser     = $signed({2'b0, cap_ff}) - $signed({16'b0, t10});
   assign abs_d     = d_ser[29] ? -d_ser : d_ser;
   assign need_par  = $signed({16'b0, t10}) - $signed({2'b0, cap_ff});
   assign c100      = {8'b0, cap_ff} * 36'd100;
   assign hi_bound  = {8'b0, t10} * {14'b0, 8'd100 + {1'b0, cfg.tolerance_pct}};
   assign lo_factor = 9'sd100 - $signed({2'b0, cfg.tolerance_pct});
   assign lo_bound  = {8'b0, t10} * {14'b0, lo_factor[7:0]};
   // a tolerance above 100 percent leaves no lower bound
   assign inside_w  = ({14'b0, hi_bound} > c100)
                      && (lo_factor[8] || (c100 > {14'b0, lo_bound}));

   always_comb begin
      div_start    = 1'b0;
      div_dividend = {28'b0, t10} * {14'b0, cap_ff};
      div_divisor  = {3'b0, abs_d};
      if (state_ff == ST_IDLE) begin
         div_dividend = DIV_N'({4'b0, cfg.cal_numerator} * 28'd10);
         div_divisor  = DIV_D'(meas_head.count);
         div_start    = meas_valid && !meas_err;
      end else if (state_ff == ST_CHECK) begin
         div_start = cfg.target_enable && cfg.series_mode && (t10 != '0)
                     && (cap_ff != '0) && (d_ser != '0);
      end
   end

   assign count_w = 33'(f_ff);

   always_comb begin
      state_in   = state_ff;
      f_in       = f_ff;
      err_in     = err_ff;
      cap_in     = cap_ff;
      inside_in  = inside_ff;
      need_in    = need_ff;
      big_in     = big_ff;
      close_in   = close_ff;
      ser_neg_in = ser_neg_ff;
      meas_pop   = 1'b0;
      rv_in      = rv_ff && !pop;
      o_freq_in  = o_freq_ff;
      o_cap_in   = o_cap_ff;
      o_err_in   = o_err_ff;
      o_ins_in   = o_ins_ff;
      o_need_in  = o_need_ff;
      o_stat_in  = o_stat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (meas_valid) begin
               meas_pop = 1'b1;
               f_in     = meas_head.count;
               err_in   = meas_err;
               cap_in   = '0;
               state_in = meas_err ? ST_CHECK : ST_DIV_CAP;
            end
         end
         ST_DIV_CAP: begin
            if (div_done) begin
               if (diff_cap[29]) begin
                  err_in = 1'b1;
                  cap_in = '0;
               end else begin
                  cap_in = diff_cap[CAP_BITS-1:0];
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            inside_in = inside_w;
            need_in   = '0;
            big_in    = 1'b0;
            close_in  = 1'b0;
            state_in  = ST_DONE;
            if (cfg.target_enable) begin
               if (!cfg.series_mode) begin
                  need_in = need_par[NEED_BITS-1:0];
                  big_in  = (need_par >= 30'sd99990) || (need_par <= -30'sd99990);
               end else if ((t10 != '0) && (cap_ff != '0)) begin
                  if (d_ser == '0) begin
                     close_in = 1'b1;
                  end else begin
                     ser_neg_in = d_ser[29];
                     state_in   = ST_DIV_SER;
                  end
               end
            end
         end
         ST_DIV_SER: begin
            if (div_done) begin
               big_in   = div_quotient >= DIV_N'(LIMIT_TENTHS);
               need_in  = ser_neg_ff ? -$signed(div_quotient[NEED_BITS-1:0])
                                     : $signed(div_quotient[NEED_BITS-1:0]);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || pop) begin
               rv_in     = 1'b1;
               o_freq_in = (count_w > 33'(FREQ_MAX)) ? FREQ_MAX : count_w[FREQ_BITS-1:0];
               o_cap_in  = cap_ff;
               o_err_in  = err_ff;
               o_ins_in  = 1'b0;
               o_need_in = '0;
               o_stat_in = STATUS_NONE;
               if (cfg.target_enable) begin
                  if (inside_ff) begin
                     o_ins_in  = 1'b1;
                     o_stat_in = STATUS_INSIDE;
                  end else if (close_ff || big_ff) begin
                     o_stat_in = STATUS_CLOSE;
                  end else begin
                     o_stat_in = STATUS_VALID;
                     o_need_in = need_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff       <= f_in;
      err_ff     <= err_in;
      cap_ff     <= cap_in;
      inside_ff  <= inside_in;
      need_ff    <= need_in;
      big_ff     <= big_in;
      close_ff   <= close_in;
      ser_neg_ff <= ser_neg_in;
      o_freq_ff  <= o_freq_in;
      o_cap_ff   <= o_cap_in;
      o_err_ff   <= o_err_in;
      o_ins_ff   <= o_ins_in;
      o_need_ff  <= o_need_in;
      o_stat_ff  <= o_stat_in;
   end

   assign empty                = !rv_ff;
   assign rsp_frequency_hz     = o_freq_ff;
   assign rsp_cap_tenths_nf    = o_cap_ff;
   assign rsp_measure_error    = o_err_ff;
   assign rsp_in_tolerance     = o_ins_ff;
   assign rsp_needed_tenths_nf = o_need_ff;
   assign rsp_needed_status    = o_stat_ff;

endmodule

// ----- rtl/core/oscillator_capacitance_meter.sv -----
// ---------------------------------------------------------------------------
// oscillator_capacitance_meter
// Gated frequency counter that reports capacitance and target checks.
// ---------------------------------------------------------------------------
// One tick is taken on every clock while push is high and full is low;
// full rises only on the last tick of a gate when two finished gates are
// still queued for the back end. Each finished gate yields one result. The
// back end handles one result at a time: the 42-step shift-subtract divider
// runs once for the capacitance and once more when the series needed value
// is divided out. A reading with a count error skips the divider.
module oscillator_capacitance_meter
   import ocm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_edge_seen,
   output logic                        empty,
   input  logic                        pop,
   output logic [FREQ_BITS-1:0]        rsp_frequency_hz,
   output logic [CAP_BITS-1:0]         rsp_cap_tenths_nf,
   output logic                        rsp_measure_error,
   output logic                        rsp_in_tolerance,
   output logic signed [NEED_BITS-1:0] rsp_needed_tenths_nf,
   output logic [1:0]                  rsp_needed_status,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_index,
   input  logic [CSR_BITS-1:0]         csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   meas_type meas_head;
   logic     meas_valid, meas_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GATE_TICKS:    cfg_in.gate_ticks       = csr_wdata[GATE_BITS-1:0];
            CSR_CAL_NUMERATOR: cfg_in.cal_numerator    = csr_wdata[CAL_BITS-1:0];
            CSR_OFFSET:        cfg_in.offset_tenths_nf = csr_wdata[OFS_BITS-1:0];
            CSR_TARGET_NF:     cfg_in.target_nf        = csr_wdata[TGT_BITS-1:0];
            CSR_TOLERANCE:     cfg_in.tolerance_pct    = csr_wdata[TOL_BITS-1:0];
            CSR_SERIES_MODE:   cfg_in.series_mode      = csr_wdata[0];
            CSR_TARGET_ENABLE: cfg_in.target_enable    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_ticks       <= GATE_BITS'(72000000);
         cfg_ff.cal_numerator    <= CAL_BITS'(240000);
         cfg_ff.offset_tenths_nf <= OFS_BITS'(60);
         cfg_ff.target_nf        <= '0;
         cfg_ff.tolerance_pct    <= '0;
         cfg_ff.series_mode      <= 1'b0;
         cfg_ff.target_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ocm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .gate_ticks (cfg_ff.gate_ticks),
      .push       (push),
      .edge_seen  (req_edge_seen),
      .full       (full),
      .meas_valid (meas_valid),
      .meas_head  (meas_head),
      .meas_pop   (meas_pop)
   );

   ocm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .meas_valid           (meas_valid),
      .meas_head            (meas_head),
      .meas_pop             (meas_pop),
      .pop                  (pop),
      .empty                (empty),
      .rsp_frequency_hz     (rsp_frequency_hz),
      .rsp_cap_tenths_nf    (rsp_cap_tenths_nf),
      .rsp_measure_error    (rsp_measure_error),
      .rsp_in_tolerance     (rsp_in_tolerance),
      .rsp_needed_tenths_nf (rsp_needed_tenths_nf),
      .rsp_needed_status    (rsp_needed_status)
   );

endmodule

// ----- rtl/core/ocm_checker.sv -----
// ---------------------------------------------------------------------------
// ocm_checker
// Port-level checks on the capacitance meter result channel.
// ---------------------------------------------------------------------------
module ocm_checker
   import ocm_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        empty,
   input logic                        pop,
   input logic [FREQ_BITS-1:0]        rsp_frequency_hz,
   input logic [CAP_BITS-1:0]         rsp_cap_tenths_nf,
   input logic                        rsp_measure_error,
   input logic                        rsp_in_tolerance,
   input logic signed [NEED_BITS-1:0] rsp_needed_tenths_nf,
   input logic [1:0]                  rsp_needed_status
);

   // waiting result holds until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_frequency_hz)
                         && $stable(rsp_cap_tenths_nf) && $stable(rsp_measure_error)
                         && $stable(rsp_in_tolerance)
                         && $stable(rsp_needed_tenths_nf) && $stable(rsp_needed_status))
      else $error("result changed before transfer");

   a_err_cap: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_measure_error |-> rsp_cap_tenths_nf == '0)
      else $error("error result with nonzero capacitance");

   a_need_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_needed_status != STATUS_VALID |-> rsp_needed_tenths_nf == '0)
      else $error("needed value without valid status");

   a_inside: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_in_tolerance |-> rsp_needed_status == STATUS_INSIDE)
      else $error("in tolerance with wrong status");

endmodule

bind oscillator_capacitance_meter ocm_checker u_ocm_checker (.*);

// ----- bench/tb_oscillator_capacitance_meter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_oscillator_capacitance_meter
// Drives oscillator ticks through the queue-style input and checks every
// gate reading against a local model of counting, capacitance and target
// logic, across directed corner settings and random configuration phases.
// ---------------------------------------------------------------------------
module tb_oscillator_capacitance_meter;
   import ocm_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 250;
   localparam int ITEM_GOAL   = 1700;

   typedef struct {
      logic [FREQ_BITS-1:0]        freq;
      logic [CAP_BITS-1:0]         cap;
      logic                        err;
      logic                        in_tol;
      logic signed [NEED_BITS-1:0] needed;
      needed_status_type           status;
   } reading_type;

   logic                        clock;
   logic                        reset;
   logic                        push;
   logic                        full;
   logic                        req_edge_seen;
   logic                        empty;
   logic                        pop;
   logic [FREQ_BITS-1:0]        rsp_frequency_hz;
   logic [CAP_BITS-1:0]         rsp_cap_tenths_nf;
   logic                        rsp_measure_error;
   logic                        rsp_in_tolerance;
   logic signed [NEED_BITS-1:0] rsp_needed_tenths_nf;
   logic [1:0]                  rsp_needed_status;
   logic                        csr_wr_en;
   logic [2:0]                  csr_index;
   logic [CSR_BITS-1:0]         csr_wdata;

   oscillator_capacitance_meter dut (.*);

   // local copy of settings and counters
   cfg_type               meter_cfg;
   logic [TICK_BITS-1:0]  tick_cnt;
   logic [COUNT_BITS-1:0] edge_cnt;
   logic                  edge_sat;

   reading_type readings_due[$];
   int          errors = 0;
   int          cycles = 0;
   int          items_sent = 0;
   int          pop_hold = 0;
   bit          no_idle = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycles, what);
      errors++;
   endtask

   function automatic reading_type gate_reading();
      reading_type r;
      longint f, cap, needed, t10, tol, c100;
      bit err, in_tol, close;
      needed_status_type st;
      f = longint'(edge_cnt);
      err = (f == 0) || edge_sat;
      cap = 0;
      needed = 0;
      in_tol = 0;
      close = 0;
      st = STATUS_NONE;
      if (!err) begin
         cap = longint'(meter_cfg.cal_numerator) * 10 / f
               - longint'(meter_cfg.offset_tenths_nf);
         if (cap < 0) begin
            err = 1;
            cap = 0;
         end
      end
      if (meter_cfg.target_enable) begin
         t10 = longint'(meter_cfg.target_nf) * 10;
         tol = longint'(meter_cfg.tolerance_pct);
         c100 = cap * 100;
         in_tol = (c100 < t10 * (100 + tol)) && (c100 > t10 * (100 - tol));
         if (meter_cfg.series_mode) begin
            if (t10 == 0 || cap == 0) needed = 0;
            else if (cap == t10) close = 1;
            else needed = (t10 * cap) / (cap - t10);
         end else begin
            needed = t10 - cap;
         end
         if (in_tol) begin
            st = STATUS_INSIDE;
            needed = 0;
         end else if (close || needed >= LIMIT_TENTHS || needed <= -LIMIT_TENTHS) begin
            st = STATUS_CLOSE;
            needed = 0;
         end else begin
            st = STATUS_VALID;
         end
      end
      r.freq = (f > longint'(FREQ_MAX)) ? FREQ_MAX : f[FREQ_BITS-1:0];
      r.cap = cap[CAP_BITS-1:0];
      r.err = err;
      r.in_tol = in_tol;
      r.needed = needed[NEED_BITS-1:0];
      r.status = st;
      return r;
   endfunction

   task automatic count_tick(input bit seen);
      logic [TICK_BITS-1:0] gate;
      gate = (meter_cfg.gate_ticks == '0) ? TICK_BITS'(1) : meter_cfg.gate_ticks;
      if (seen) begin
         if (edge_cnt == '1) edge_sat = 1'b1;
         else edge_cnt++;
      end
      tick_cnt++;
      if (tick_cnt >= gate) begin
         readings_due.push_back(gate_reading());
         tick_cnt = '0;
         edge_cnt = '0;
         edge_sat = 1'b0;
      end
   endtask

   task automatic send_tick(input bit seen);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_edge_seen <= seen;
      do @(posedge clock); while (full);
      count_tick(seen);
      items_sent++;
   endtask

   // stop sending and wait out every pending reading plus back-end latency
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type c);
      write_csr(CSR_GATE_TICKS, CSR_BITS'(c.gate_ticks));
      write_csr(CSR_CAL_NUMERATOR, CSR_BITS'(c.cal_numerator));
      write_csr(CSR_OFFSET, CSR_BITS'(c.offset_tenths_nf));
      write_csr(CSR_TARGET_NF, CSR_BITS'(c.target_nf));
      write_csr(CSR_TOLERANCE, CSR_BITS'(c.tolerance_pct));
      write_csr(CSR_SERIES_MODE, CSR_BITS'(c.series_mode));
      write_csr(CSR_TARGET_ENABLE, CSR_BITS'(c.target_enable));
      csr_wr_en <= 1'b0;
      meter_cfg = c;
   endtask

   function automatic cfg_type make_cfg(input logic [31:0] gate, input logic [23:0] cal,
                                        input logic [15:0] ofs, input logic [9:0] tgt,
                                        input logic [6:0] tol, input bit ser, input bit en);
      cfg_type c;
      c.gate_ticks = gate;
      c.cal_numerator = cal;
      c.offset_tenths_nf = ofs;
      c.target_nf = tgt;
      c.tolerance_pct = tol;
      c.series_mode = ser;
      c.target_enable = en;
      return c;
   endfunction

   // result side: random stalls, one check per transfer
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (readings_due.size() == 0) begin
               report_mismatch("reading with none expected");
            end else begin
               reading_type e;
               e = readings_due.pop_front();
               if (rsp_frequency_hz !== e.freq)
                  report_mismatch($sformatf("freq %0d want %0d", rsp_frequency_hz, e.freq));
               if (rsp_cap_tenths_nf !== e.cap)
                  report_mismatch($sformatf("cap %0d want %0d", rsp_cap_tenths_nf, e.cap));
               if (rsp_measure_error !== e.err)
                  report_mismatch($sformatf("error %b want %b", rsp_measure_error, e.err));
               if (rsp_in_tolerance !== e.in_tol)
                  report_mismatch($sformatf("in_tol %b want %b", rsp_in_tolerance, e.in_tol));
               if (rsp_needed_tenths_nf !== e.needed)
                  report_mismatch($sformatf("needed %0d want %0d",
                                            rsp_needed_tenths_nf, e.needed));
               if (rsp_needed_status !== e.status)
                  report_mismatch($sformatf("status %0d want %0d",
                                            rsp_needed_status, e.status));
            end
         end
         if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            pop_hold <= pick_gap();
         end
      end
   end

   task automatic test_corner_settings();
      // huge capacitance, then zero count; parallel need far too large
      configure(make_cfg(1, 24'hFFFFFF, 0, 1, 5, 0, 1));
      send_tick(1);
      send_tick(0);
      drain();
      // gate of zero; series equal pair, then series with zero capacitance
      configure(make_cfg(0, 100, 0, 100, 0, 1, 1));
      send_tick(1);
      send_tick(0);
      drain();
      // offset drives value negative; tolerance beyond 100 percent
      configure(make_cfg(1, 100, 16'hFFFF, 1000, 7'h7F, 0, 1));
      send_tick(1);
      send_tick(1);
      drain();
      configure(make_cfg(2, 1000, 0, 1000, 100, 0, 1));
      send_tick(1);
      send_tick(1);
      drain();
      // series with a valid needed value, zero target in series
      configure(make_cfg(2, 1000, 0, 1, 0, 1, 1));
      send_tick(1);
      send_tick(1);
      drain();
      configure(make_cfg(1, 1000, 0, 0, 0, 1, 1));
      send_tick(1);
      drain();
   endtask

   task automatic test_long_gate();
      // longest gate never ends here; shortening it closes the gate at once
      configure(make_cfg(32'hFFFFFFFF, 240000, 60, 0, 0, 0, 0));
      send_tick(1);
      send_tick(0);
      send_tick(1);
      drain();
      configure(make_cfg(2, 240000, 60, 0, 0, 0, 0));
      send_tick(1);
      send_tick(1);
      drain();
   endtask

   task automatic test_random_phases();
      cfg_type c;
      int n, dens, want, f_est, cap_est;
      while (items_sent < ITEM_GOAL) begin
         no_idle = ($urandom_range(0, 5) == 0);
         c.gate_ticks = GATE_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                               : $urandom_range(0, 40));
         dens = $urandom_range(0, 100);
         f_est = (c.gate_ticks * dens) / 100;
         if (f_est == 0) f_est = 1;
         c.offset_tenths_nf = OFS_BITS'(($urandom_range(0, 7) == 0) ? $urandom()
                                                                   : $urandom_range(0, 200));
         want = $urandom_range(0, 10500) + c.offset_tenths_nf;
         c.cal_numerator = CAL_BITS'(($urandom_range(0, 5) == 0) ? $urandom()
                                                                 : (want * f_est) / 10);
         cap_est = (c.cal_numerator * 10) / f_est - c.offset_tenths_nf;
         if (cap_est < 0) cap_est = 0;
         if ($urandom_range(0, 2) == 0 || cap_est > 10000)
            c.target_nf = TGT_BITS'($urandom_range(0, 1023));
         else c.target_nf = TGT_BITS'(cap_est / 10 + $urandom_range(0, 4) - 2);
         c.tolerance_pct = TOL_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
                                                                 : $urandom_range(0, 100));
         c.series_mode = ($urandom_range(0, 1) == 1);
         c.target_enable = ($urandom_range(0, 4) != 0);
         configure(c);
         n = $urandom_range(30, 140);
         repeat (n) send_tick($urandom_range(0, 99) < dens);
         drain();
      end
      no_idle = 0;
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_edge_seen <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_GATE_TICKS;
      csr_wdata <= '0;
      meter_cfg = make_cfg(72000000, 240000, 60, 0, 0, 0, 0);
      tick_cnt = '0;
      edge_cnt = '0;
      edge_sat = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_settings();
      test_long_gate();
      test_random_phases();
      drain();
      if (errors == 0 && readings_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
